// ===== sv/xlrd_pkg.sv =====
// ============================================================================
// XOR LZSS ring decoder package
// Shared constants, codes and the command and status bundles that pass
// between the decoder controller and its datapath.
// ============================================================================
package xlrd_pkg;

   // Ring buffer geometry.
   localparam int RING_AW    = 12;
   localparam int RING_DEPTH = 1 << RING_AW;

   // Field widths.
   localparam int DATA_BITS     = 8;
   localparam int LIMIT_BITS    = 32;
   localparam int REPORT_BITS   = 32;
   localparam int STATUS_BITS   = 2;
   localparam int LEN_BITS      = 5;
   localparam int FLAG_BITS     = 9;
   localparam int RSP_DATA_BITS = 80;

   // Default width of the produced and consumed counters.
   localparam int COUNT_BITS_DEF = 32;

   // Stream coding constants.
   localparam logic [DATA_BITS-1:0] XOR_KEY   = 8'hB5;
   localparam logic [RING_AW-1:0]   POS_BIAS  = 12'd18;
   localparam logic [LEN_BITS-1:0]  MIN_LEN   = 5'd3;
   localparam logic [FLAG_BITS-1:0] FLAG_MARK = 9'h100;

   // Request modes.
   localparam logic MODE_DATA = 1'b0;
   localparam logic MODE_END  = 1'b1;

   // Response kinds.
   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_END  = 1'b1;

   // End-of-stream status codes.
   localparam logic [STATUS_BITS-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_SHORT     = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_EXCEEDED  = 2'd2;
   localparam logic [STATUS_BITS-1:0] ST_ZERO_SCAN = 2'd3;

   // Configuration register indexes.
   localparam logic CSR_LIMIT = 1'b0;
   localparam logic CSR_EXACT = 1'b1;

   // What a data byte turns out to be once decoded.
   localparam logic [1:0] DEC_FLAG    = 2'd0;
   localparam logic [1:0] DEC_LIT     = 2'd1;
   localparam logic [1:0] DEC_PAIR_LO = 2'd2;
   localparam logic [1:0] DEC_MATCH   = 2'd3;

   // Controller to datapath commands.
   typedef struct packed {
      logic latch;      // capture the accepted request
      logic decode;     // apply the token decode of the held byte
      logic rd_en;      // read the ring at the copy source
      logic emit_lit;   // emit the held byte as a literal
      logic emit_copy;  // emit the ring byte that was read
      logic emit_end;   // emit the status response and clear the stream
      logic set_ovf;    // mark the output limit as overrun
   } xlrd_cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic       is_end;
      logic       ovf;
      logic [1:0] dec_kind;
      logic       at_limit;
      logic       next_at_limit;
      logic       cnt_one;
      logic       out_free;
   } xlrd_stat_type;

endpackage

// ===== sv/xlrd_ctrl.sv =====
// ============================================================================
// XOR LZSS ring decoder controller
// Sequences one request at a time: decode, literal output, match copy and
// the end-of-stream status.
// ============================================================================
module xlrd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  xlrd_pkg::xlrd_stat_type stat,
   output xlrd_pkg::xlrd_cmd_type  cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_LIT    = 3'd2;
   localparam logic [2:0] S_READ   = 3'd3;
   localparam logic [2:0] S_EMIT   = 3'd4;
   localparam logic [2:0] S_END    = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   // Next state and commands.
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.latch = 1'b1;
               state_in  = S_DECODE;
            end
         end
         S_DECODE: begin
            if (stat.is_end) begin
               state_in = S_END;
            end else if (stat.ovf) begin
               state_in = S_IDLE;
            end else begin
               cmd.decode = 1'b1;
               unique case (stat.dec_kind)
                  xlrd_pkg::DEC_MATCH: state_in = S_READ;
                  xlrd_pkg::DEC_LIT:   state_in = S_LIT;
                  default:             state_in = S_IDLE;
               endcase
            end
         end
         S_LIT: begin
            if (stat.at_limit) begin
               cmd.set_ovf = 1'b1;
               state_in    = S_IDLE;
            end else if (stat.out_free) begin
               cmd.emit_lit = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_READ: begin
            if (stat.at_limit) begin
               cmd.set_ovf = 1'b1;
               state_in    = S_IDLE;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = S_EMIT;
            end
         end
         S_EMIT: begin
            if (stat.out_free) begin
               cmd.emit_copy = 1'b1;
               if (stat.cnt_one) begin
                  state_in = S_IDLE;
               end else if (stat.next_at_limit) begin
                  cmd.set_ovf = 1'b1;
                  state_in    = S_IDLE;
               end else begin
                  // Fetch the next source byte while this one goes out.
                  cmd.rd_en = 1'b1;
               end
            end
         end
         S_END: begin
            if (stat.out_free) begin
               cmd.emit_end = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== sv/xlrd_dpath.sv =====
// ============================================================================
// XOR LZSS ring decoder datapath
// Holds the configuration, the token decode state, the counters, the 4 KiB
// history ring and the response register.
// ============================================================================
module xlrd_dpath #(
   parameter int COUNT_BITS = xlrd_pkg::COUNT_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [xlrd_pkg::DATA_BITS-1:0]       req_tdata,
   input  logic                                 req_tuser,
   input  logic                                 csr_valid,
   input  logic                                 csr_index,
   input  logic [xlrd_pkg::LIMIT_BITS-1:0]      csr_data,
   input  xlrd_pkg::xlrd_cmd_type               cmd,
   output xlrd_pkg::xlrd_stat_type              stat,
   input  logic                                 rsp_tready,
   output logic                                 rsp_tvalid,
   output logic                                 rsp_tuser,
   output logic                                 rsp_tlast,
   output logic [xlrd_pkg::RSP_DATA_BITS-1:0]   rsp_tdata
);

   localparam int AW   = xlrd_pkg::RING_AW;
   localparam int DW   = xlrd_pkg::DATA_BITS;
   localparam int WIDE = (COUNT_BITS > xlrd_pkg::LIMIT_BITS) ? COUNT_BITS
                                                              : xlrd_pkg::LIMIT_BITS;
   localparam int PAD  = xlrd_pkg::RSP_DATA_BITS - DW - xlrd_pkg::STATUS_BITS
                         - 2 * xlrd_pkg::REPORT_BITS;

   // Token phase codes; the unused code behaves like PH_ITEM.
   localparam logic [1:0] PH_ITEM       = 2'd0;
   localparam logic [1:0] PH_AFTER_FLAG = 2'd1;
   localparam logic [1:0] PH_PAIR       = 2'd2;

   // Configuration registers.
   logic [xlrd_pkg::LIMIT_BITS-1:0] limit_ff;
   logic                            exact_ff;

   // Held request.
   logic [DW-1:0] byte_ff;
   logic          mode_ff;

   // Stream state.
   logic [AW-1:0]                  cursor_ff, cursor_in;
   logic                           full_ff, full_in;
   logic [xlrd_pkg::FLAG_BITS-1:0] flag_ff, flag_in;
   logic [1:0]                     phase_ff, phase_in;
   logic [DW-1:0]                  pending_ff, pending_in;
   logic [COUNT_BITS-1:0]          out_total_ff, out_total_in;
   logic [COUNT_BITS-1:0]          in_total_ff, in_total_in;
   logic                           ovf_ff, ovf_in;

   // Match copy state.
   logic [AW-1:0]                 src_ff, src_in;
   logic [xlrd_pkg::LEN_BITS-1:0] cnt_ff, cnt_in;

   // History ring and its registered read port.
   logic [DW-1:0] ring [xlrd_pkg::RING_DEPTH];
   logic [DW-1:0] rd_raw_ff;
   logic [DW-1:0] rd_byp_ff;
   logic          rd_hit_ff;
   logic          rd_ok_ff;

   // Response register.
   logic                                rsp_valid_ff;
   logic                                rsp_kind_ff;
   logic                                rsp_last_ff;
   logic [DW-1:0]                       rsp_byte_ff;
   logic [xlrd_pkg::STATUS_BITS-1:0]    rsp_status_ff;
   logic [xlrd_pkg::REPORT_BITS-1:0]    rsp_prod_ff;
   logic [xlrd_pkg::REPORT_BITS-1:0]    rsp_cons_ff;

   logic [xlrd_pkg::FLAG_BITS-1:0]   shifted;
   logic [xlrd_pkg::FLAG_BITS-1:0]   flag_cur;
   logic [1:0]                       dec_kind;
   logic [COUNT_BITS-1:0]            out_next;
   logic [WIDE-1:0]                  limit_wide;
   logic                             out_free;
   logic                             wr_en;
   logic [DW-1:0]                    copy_byte;
   logic [DW-1:0]                    emit_data;
   logic                             rd_hit;
   logic [xlrd_pkg::STATUS_BITS-1:0] end_status;
   logic                             end_ok;

   // Token decode of the held byte.
   always_comb begin
      shifted  = flag_ff >> 1;
      flag_cur = (phase_ff == PH_AFTER_FLAG) ? flag_ff : shifted;
      if (phase_ff == PH_PAIR) begin
         dec_kind = xlrd_pkg::DEC_MATCH;
      end else if (phase_ff != PH_AFTER_FLAG && shifted <= xlrd_pkg::FLAG_BITS'(1)) begin
         dec_kind = xlrd_pkg::DEC_FLAG;
      end else if (flag_cur[0]) begin
         dec_kind = xlrd_pkg::DEC_LIT;
      end else begin
         dec_kind = xlrd_pkg::DEC_PAIR_LO;
      end
   end

   // Limit checks and end status.
   assign out_next   = out_total_ff + COUNT_BITS'(1);
   assign limit_wide = WIDE'(limit_ff);

   always_comb begin
      end_ok = 1'b0;
      if (!exact_ff && limit_ff == '0) begin
         end_status = xlrd_pkg::ST_ZERO_SCAN;
      end else if (ovf_ff) begin
         end_status = xlrd_pkg::ST_EXCEEDED;
      end else if (exact_ff && WIDE'(out_total_ff) != limit_wide) begin
         end_status = xlrd_pkg::ST_SHORT;
      end else begin
         end_status = xlrd_pkg::ST_OK;
         end_ok     = 1'b1;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      stat               = '0;
      stat.is_end        = (mode_ff == xlrd_pkg::MODE_END);
      stat.ovf           = ovf_ff;
      stat.dec_kind      = dec_kind;
      stat.at_limit      = WIDE'(out_total_ff) >= limit_wide;
      stat.next_at_limit = WIDE'(out_next) >= limit_wide;
      stat.cnt_one       = (cnt_ff == xlrd_pkg::LEN_BITS'(1));
      stat.out_free      = out_free;
   end

   // Output byte and ring write. A location not yet written since the
   // last clear reads as zero; a read of the location written in the same
   // cycle takes the new byte.
   assign copy_byte = !rd_ok_ff ? '0 : (rd_hit_ff ? rd_byp_ff : rd_raw_ff);
   assign emit_data = cmd.emit_lit ? byte_ff : copy_byte;
   assign wr_en     = cmd.emit_lit || cmd.emit_copy;
   assign rd_hit    = wr_en && (src_ff == cursor_ff);

   // Next stream state.
   always_comb begin
      cursor_in    = cursor_ff;
      full_in      = full_ff;
      flag_in      = flag_ff;
      phase_in     = phase_ff;
      pending_in   = pending_ff;
      out_total_in = out_total_ff;
      in_total_in  = in_total_ff;
      ovf_in       = ovf_ff;
      src_in       = src_ff;
      cnt_in       = cnt_ff;

      if (cmd.decode) begin
         in_total_in = in_total_ff + COUNT_BITS'(1);
         case (dec_kind)
            xlrd_pkg::DEC_MATCH: begin
               phase_in = PH_ITEM;
               src_in   = {byte_ff[7:4], pending_ff} + xlrd_pkg::POS_BIAS;
               cnt_in   = xlrd_pkg::LEN_BITS'(byte_ff[3:0]) + xlrd_pkg::MIN_LEN;
            end
            xlrd_pkg::DEC_FLAG: begin
               flag_in  = xlrd_pkg::FLAG_BITS'(byte_ff) | xlrd_pkg::FLAG_MARK;
               phase_in = PH_AFTER_FLAG;
            end
            xlrd_pkg::DEC_LIT: begin
               flag_in  = flag_cur;
               phase_in = PH_ITEM;
            end
            default: begin
               flag_in    = flag_cur;
               pending_in = byte_ff;
               phase_in   = PH_PAIR;
            end
         endcase
      end

      if (cmd.rd_en) begin
         src_in = src_ff + AW'(1);
      end

      if (wr_en) begin
         cursor_in    = cursor_ff + AW'(1);
         out_total_in = out_next;
         if (cursor_ff == '1) begin
            full_in = 1'b1;
         end
      end

      if (cmd.emit_copy) begin
         cnt_in = cnt_ff - xlrd_pkg::LEN_BITS'(1);
      end

      if (cmd.set_ovf) begin
         ovf_in = 1'b1;
      end

      // The end of a stream returns the stream state to its reset value; the configuration is kept.
      if (cmd.emit_end) begin
         cursor_in    = '0;
         full_in      = 1'b0;
         flag_in      = '0;
         phase_in     = PH_ITEM;
         pending_in   = '0;
         out_total_in = '0;
         in_total_in  = '0;
         ovf_in       = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= '0;
         exact_ff     <= 1'b1;
         cursor_ff    <= '0;
         full_ff      <= 1'b0;
         flag_ff      <= '0;
         phase_ff     <= PH_ITEM;
         pending_ff   <= '0;
         out_total_ff <= '0;
         in_total_ff  <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               xlrd_pkg::CSR_LIMIT: limit_ff <= csr_data;
               default:             exact_ff <= csr_data[0];
            endcase
         end
         cursor_ff    <= cursor_in;
         full_ff      <= full_in;
         flag_ff      <= flag_in;
         phase_ff     <= phase_in;
         pending_ff   <= pending_in;
         out_total_ff <= out_total_in;
         in_total_ff  <= in_total_in;
         ovf_ff       <= ovf_in;
         if (wr_en || cmd.emit_end) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      src_ff <= src_in;
      cnt_ff <= cnt_in;
      if (cmd.latch) begin
         byte_ff <= req_tdata ^ xlrd_pkg::XOR_KEY;
         mode_ff <= req_tuser;
      end
      if (wr_en) begin
         rsp_kind_ff   <= xlrd_pkg::KIND_BYTE;
         rsp_byte_ff   <= emit_data;
         rsp_last_ff   <= cmd.emit_lit || stat.cnt_one || stat.next_at_limit;
         rsp_status_ff <= xlrd_pkg::ST_OK;
         rsp_prod_ff   <= '0;
         rsp_cons_ff   <= '0;
      end else if (cmd.emit_end) begin
         rsp_kind_ff   <= xlrd_pkg::KIND_END;
         rsp_byte_ff   <= '0;
         rsp_last_ff   <= 1'b1;
         rsp_status_ff <= end_status;
         rsp_prod_ff   <= end_ok ? xlrd_pkg::REPORT_BITS'(WIDE'(out_total_ff)) : '0;
         rsp_cons_ff   <= end_ok ? xlrd_pkg::REPORT_BITS'(WIDE'(in_total_ff)) : '0;
      end
   end

   // History ring: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring[cursor_ff] <= emit_data;
      end
      if (cmd.rd_en) begin
         rd_raw_ff <= ring[src_ff];
         rd_byp_ff <= emit_data;
         rd_hit_ff <= rd_hit;
         rd_ok_ff  <= full_ff || (src_ff < cursor_ff) || rd_hit;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {PAD'(0), rsp_cons_ff, rsp_prod_ff, rsp_status_ff, rsp_byte_ff};

endmodule

// ===== sv/xor_lzss_ring_decoder.sv =====
// ============================================================================
// XOR LZSS ring decoder
// Decodes an XOR-scrambled LZSS byte stream against a 4 KiB history ring and
// closes each stream with a status response that carries the byte counts on success.
// ============================================================================
// The decoder takes one request at a time and holds it until all its
// responses have been handed to the response register. A data byte is
// accepted and then decoded; a literal is then output, while a match first
// reads the ring and then copies its bytes, the longest match being 18
// bytes. The copy rate is set by the single ring read port. An end request
// is accepted, seen in the decode state and answered with the status
// response. The ring needs no clearing pass: the write cursor and a wrap
// bit track which locations have been written since the last end of
// stream, and all others read as zero. Configuration writes are always
// accepted and must only be issued while the decoder is idle.
module xor_lzss_ring_decoder #(
   parameter int COUNT_BITS = xlrd_pkg::COUNT_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // Request channel.
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [xlrd_pkg::DATA_BITS-1:0]     req_tdata,   // [7:0] in_byte
   input  logic                               req_tuser,   // [0] mode
   // Response channel.
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [7:0] out_byte, [9:8] status, [41:10] produced_count,
   // [73:42] consumed_count, [79:74] zero
   output logic [xlrd_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   output logic                               rsp_tuser,   // [0] kind
   output logic                               rsp_tlast,
   // Configuration write channel.
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic                               csr_index,
   input  logic [xlrd_pkg::LIMIT_BITS-1:0]    csr_data
);

   xlrd_pkg::xlrd_cmd_type  cmd;
   xlrd_pkg::xlrd_stat_type stat;

   assign csr_ready = 1'b1;

   xlrd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   xlrd_dpath #(
      .COUNT_BITS (COUNT_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
